/* hdl/csvtok_pkg.sv */
`timescale 1ns / 1ps

package csvtok_pkg;

    localparam int FIELD_MAX_LEN_DEF = 32;
    localparam int MAX_FIELDS_DEF    = 16;
    localparam int HOLD_DEPTH        = 32;
    localparam int HCNT_W            = $clog2(HOLD_DEPTH + 1);
    localparam int HIDX_W            = $clog2(HOLD_DEPTH);
    localparam int Q_DEPTH           = 4;
    localparam int Q_AW              = $clog2(Q_DEPTH);
    localparam int CMP_W             = 8;

    localparam logic [4:0] FIELD_COUNT_RST = 5'd12;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    localparam logic [2:0] KIND_CHAR = 3'd0;
    localparam logic [2:0] KIND_FEND = 3'd1;
    localparam logic [2:0] KIND_REND = 3'd2;
    localparam logic [2:0] KIND_ERR  = 3'd3;
    localparam logic [2:0] KIND_DROP = 3'd4;

    localparam logic [1:0] ERR_TOO_LONG  = 2'd0;
    localparam logic [1:0] ERR_TOO_MANY  = 2'd1;
    localparam logic [1:0] ERR_TOO_FEW   = 2'd2;

    // classified input byte
    typedef struct packed {
        logic [7:0] text_byte;
        logic       is_end;
        logic       is_nul;
        logic       is_comma;
        logic       is_quote;
        logic       is_blank;
        logic       is_tab;
        logic       is_hash;
    } cls_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] field_index;
        logic [7:0] out_char;
        logic [1:0] error_code;
    } res_t;

endpackage

/* hdl/csvtok_front.sv */
`timescale 1ns / 1ps

module csvtok_front
(
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // text_byte
    input  logic                q_full,
    output logic                q_push,
    output csvtok_pkg::cls_t    q_entry
);
    import csvtok_pkg::*;

    logic [7:0] b;

    assign b             = s_axis_tdata;
    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    always_comb
    begin
        q_entry.text_byte = b;
        q_entry.is_nul    = (b == CH_NUL);
        q_entry.is_end    = (b == CH_NUL) || (b == CH_LF) || (b == CH_CR);
        q_entry.is_comma  = (b == CH_COMMA);
        q_entry.is_quote  = (b == CH_QUOTE);
        q_entry.is_tab    = (b == CH_TAB);
        q_entry.is_blank  = (b == CH_TAB) || (b == CH_SPACE);
        q_entry.is_hash   = (b == CH_HASH);
    end

endmodule

/* hdl/csvtok_queue.sv */
`timescale 1ns / 1ps

module csvtok_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  csvtok_pkg::cls_t    push_entry,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output csvtok_pkg::cls_t    head_entry
);
    import csvtok_pkg::*;

    cls_t              mem_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]     cnt_reg, cnt_next;
    logic              do_pop;

    assign full       = (cnt_reg == (Q_AW+1)'(Q_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (Q_AW+1)'(push) - (Q_AW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* hdl/csvtok_back.sv */
`timescale 1ns / 1ps

module csvtok_back
#(
    parameter int FIELD_MAX_LEN = csvtok_pkg::FIELD_MAX_LEN_DEF,
    parameter int MAX_FIELDS    = csvtok_pkg::MAX_FIELDS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [4:0]          field_count,
    input  logic                cmd_valid,
    input  csvtok_pkg::cls_t    cmd,
    output logic                cmd_pop,
    output logic                res_valid,
    input  logic                res_ready,
    output csvtok_pkg::res_t    res
);
    import csvtok_pkg::*;

    localparam int LEN_W = $clog2(FIELD_MAX_LEN + 1);
    localparam int FN_W  = (MAX_FIELDS > 2) ? $clog2(MAX_FIELDS) : 1;

    logic                 skip_reg, skip_next;
    logic                 inq_reg, inq_next;
    logic                 qpc_reg, qpc_next;
    logic [FN_W-1:0]      fn_reg, fn_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [HCNT_W-1:0]    hcnt_reg, hcnt_next;
    logic [HIDX_W-1:0]    fidx_reg, fidx_next;
    logic [HOLD_DEPTH-1:0] tab_reg;
    logic                 out_valid_reg, out_valid_next;
    res_t                 out_reg, out_next;

    logic                 go;
    logic                 emit;
    logic                 hold_wr;
    logic                 iq;
    logic                 len_full;
    logic                 need_flush;
    logic                 blank_tab;
    logic [CMP_W-1:0]     fc8, cnt8, fn8, fn1;
    logic [3:0]           idx;

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_comb
    begin
        fc8 = CMP_W'(field_count);
        if (fc8 < CMP_W'(2))
            cnt8 = CMP_W'(2);
        else if (fc8 > CMP_W'(MAX_FIELDS))
            cnt8 = CMP_W'(MAX_FIELDS);
        else
            cnt8 = fc8;
        fn8 = CMP_W'(fn_reg);
        fn1 = fn8 + CMP_W'(1);
        idx = fn8[3:0];
    end

    assign len_full  = (len_reg >= LEN_W'(FIELD_MAX_LEN));
    assign blank_tab = tab_reg[fidx_reg];
    assign go        = cmd_valid && (!out_valid_reg || res_ready);

    // held blanks only exist in an unquoted field with characters
    assign need_flush = (hcnt_reg != '0) &&
                        (cmd.is_nul ||
                         (!cmd.is_end && !cmd.is_comma &&
                          !(cmd.is_quote && len_reg == '0) &&
                          (!cmd.is_blank || hcnt_reg == HCNT_W'(HOLD_DEPTH))));

    always_comb
    begin
        skip_next = skip_reg;
        inq_next  = inq_reg;
        qpc_next  = qpc_reg;
        fn_next   = fn_reg;
        len_next  = len_reg;
        hcnt_next = hcnt_reg;
        fidx_next = fidx_reg;
        cmd_pop   = 1'b0;
        emit      = 1'b0;
        hold_wr   = 1'b0;
        iq        = inq_reg && !qpc_reg;
        out_next  = out_reg;
        out_next.kind        = KIND_CHAR;
        out_next.field_index = idx;
        out_next.out_char    = '0;
        out_next.error_code  = ERR_TOO_LONG;

        if (go)
        begin
            if (skip_reg)
            begin
                cmd_pop = 1'b1;
                if (cmd.is_end)
                begin
                    skip_next = 1'b0;
                    inq_next  = 1'b0;
                    qpc_next  = 1'b0;
                    fn_next   = '0;
                    len_next  = '0;
                    hcnt_next = '0;
                    fidx_next = '0;
                end
            end
            else if (qpc_reg && cmd.is_quote)
            begin
                qpc_next = 1'b0;
                cmd_pop  = 1'b1;
            end
            else
            begin
                qpc_next = 1'b0;
                if (qpc_reg)
                    inq_next = 1'b0;

                if (need_flush)
                begin
                    emit = 1'b1;
                    if (len_full)
                    begin
                        out_next.kind = KIND_ERR;
                        hcnt_next     = '0;
                        fidx_next     = '0;
                        cmd_pop       = 1'b1;
                        if (cmd.is_nul)
                        begin
                            inq_next = 1'b0;
                            qpc_next = 1'b0;
                            fn_next  = '0;
                            len_next = '0;
                        end
                        else
                        begin
                            skip_next = 1'b1;
                        end
                    end
                    else
                    begin
                        out_next.out_char = blank_tab ? CH_TAB : CH_SPACE;
                        len_next          = len_reg + 1'b1;
                        if (HCNT_W'(fidx_reg) + 1'b1 == hcnt_reg)
                        begin
                            hcnt_next = '0;
                            fidx_next = '0;
                        end
                        else
                        begin
                            fidx_next = fidx_reg + 1'b1;
                        end
                    end
                end
                else
                begin
                    cmd_pop = 1'b1;
                    priority if (cmd.is_end)
                    begin
                        emit = 1'b1;
                        if (fn_reg == '0)
                        begin
                            out_next.kind = KIND_DROP;
                        end
                        else if (fn1 != cnt8)
                        begin
                            out_next.kind       = KIND_ERR;
                            out_next.error_code = ERR_TOO_FEW;
                        end
                        else
                        begin
                            out_next.kind = KIND_REND;
                        end
                        inq_next  = 1'b0;
                        qpc_next  = 1'b0;
                        fn_next   = '0;
                        len_next  = '0;
                        hcnt_next = '0;
                        fidx_next = '0;
                    end
                    else if (cmd.is_hash && fn_reg == '0 && len_reg == '0)
                    begin
                        emit          = 1'b1;
                        out_next.kind = KIND_DROP;
                        skip_next     = 1'b1;
                    end
                    else if (iq)
                    begin
                        if (cmd.is_quote)
                        begin
                            qpc_next = 1'b1;
                        end
                        else
                        begin
                            emit = 1'b1;
                            if (len_full)
                            begin
                                out_next.kind = KIND_ERR;
                                skip_next     = 1'b1;
                                hcnt_next     = '0;
                            end
                            else
                            begin
                                out_next.out_char = cmd.text_byte;
                                len_next          = len_reg + 1'b1;
                            end
                        end
                    end
                    else if (cmd.is_quote && len_reg == '0)
                    begin
                        inq_next = 1'b1;
                    end
                    else if (cmd.is_comma)
                    begin
                        emit      = 1'b1;
                        hcnt_next = '0;
                        fidx_next = '0;
                        if (fn1 >= cnt8)
                        begin
                            out_next.kind       = KIND_ERR;
                            out_next.error_code = ERR_TOO_MANY;
                            skip_next           = 1'b1;
                        end
                        else
                        begin
                            out_next.kind = KIND_FEND;
                            fn_next       = fn_reg + 1'b1;
                            len_next      = '0;
                        end
                    end
                    else if (cmd.is_blank)
                    begin
                        if (len_reg != '0)
                        begin
                            hold_wr   = 1'b1;
                            hcnt_next = hcnt_reg + 1'b1;
                        end
                    end
                    else if (!cmd.is_quote)
                    begin
                        emit = 1'b1;
                        if (len_full)
                        begin
                            out_next.kind = KIND_ERR;
                            skip_next     = 1'b1;
                            hcnt_next     = '0;
                        end
                        else
                        begin
                            out_next.out_char = cmd.text_byte;
                            len_next          = len_reg + 1'b1;
                        end
                    end
                end
            end
        end

        if (emit)
            out_valid_next = 1'b1;
        else if (res_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg      <= 1'b0;
            inq_reg       <= 1'b0;
            qpc_reg       <= 1'b0;
            fn_reg        <= '0;
            len_reg       <= '0;
            hcnt_reg      <= '0;
            fidx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            skip_reg      <= skip_next;
            inq_reg       <= inq_next;
            qpc_reg       <= qpc_next;
            fn_reg        <= fn_next;
            len_reg       <= len_next;
            hcnt_reg      <= hcnt_next;
            fidx_reg      <= fidx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            out_reg <= out_next;
        if (hold_wr)
            tab_reg[hcnt_reg[HIDX_W-1:0]] <= cmd.is_tab;
    end

endmodule

/* hdl/csv_field_tokenizer.sv */
`timescale 1ns / 1ps

// CSV field tokenizer.
// s_axis: one text byte per transfer. m_axis: one token per transfer,
// tuser = kind (char, field end, record end, error, line dropped).
// cfg: writes field_count, the number of fields a record must have;
// write only while the block is idle.
// A byte passes the queue and then the output register. Throughput: one
// byte per cycle while the output is not stalled. A byte that releases held
// blanks (non-blank after inner blanks, NUL, or a blank into a full store)
// first emits its n held blanks, n <= 32, one output transfer per cycle while
// not stalled, from the single execution unit. A byte yields 0 to 33 tokens.
// A four-entry queue sits between byte intake and execution.
// Reset: line state cleared, queue empty, field_count = 12.
// Output stall: the output register holds, execution stops, the queue
// fills and s_axis_tready drops after at most four more bytes.
module csv_field_tokenizer
#(
    parameter int FIELD_MAX_LEN = csvtok_pkg::FIELD_MAX_LEN_DEF,
    parameter int MAX_FIELDS    = csvtok_pkg::MAX_FIELDS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [3:0] field_index, [11:4] out_char,
                                        // [13:12] error_code, [15:14] zero
    output logic [2:0]  m_axis_tuser,   // [2:0] kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data        // field_count
);
    import csvtok_pkg::*;

    logic [4:0] fc_reg;
    logic       q_full;
    logic       q_push;
    cls_t       q_entry;
    logic       head_valid;
    cls_t       head_entry;
    logic       cmd_pop;
    res_t       res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fc_reg <= FIELD_COUNT_RST;
        else if (cfg_valid && cfg_ready)
            fc_reg <= cfg_data;
    end

    csvtok_front u_front
    (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_entry       (q_entry)
    );

    csvtok_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (cmd_pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    csvtok_back
    #(
        .FIELD_MAX_LEN (FIELD_MAX_LEN),
        .MAX_FIELDS    (MAX_FIELDS)
    )
    u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .field_count (fc_reg),
        .cmd_valid   (head_valid),
        .cmd         (head_entry),
        .cmd_pop     (cmd_pop),
        .res_valid   (m_axis_tvalid),
        .res_ready   (m_axis_tready),
        .res         (res)
    );

    assign m_axis_tuser = res.kind;
    assign m_axis_tdata = {2'b00, res.error_code, res.out_char, res.field_index};

endmodule

/* hdl/csvtok_check.sv */
`timescale 1ns / 1ps

module csvtok_check
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);
    import csvtok_pkg::*;

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= KIND_DROP))
        else $error("token kind out of range");

    a_char_only: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != KIND_CHAR) |->
            (m_axis_tdata[11:4] == 8'h00))
        else $error("character on a non-character token");

    a_code_only: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != KIND_ERR) |->
            (m_axis_tdata[13:12] == ERR_TOO_LONG && m_axis_tdata[15:14] == 2'b00))
        else $error("error code on a non-error token");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled token changed");

endmodule

bind csv_field_tokenizer csvtok_check u_csvtok_check
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
